### sv/fdf_pkg.sv
// ----------------------------------------------------------------------------
// fdf_pkg
// Shared constants, coefficient sets and control types of the dual-depth
// FIR filter unit.
// ----------------------------------------------------------------------------
package fdf_pkg;

	localparam int HIST_DEPTH      = 8;
	localparam int LONG_TAPS_DEF   = 8;
	localparam int SHORT_TAPS_DEF  = 4;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COEF_BITS       = 16;
	localparam int FRAC_BITS       = 15;

	// q1.15 low-pass sets, tap 0 weights the newest sample
	localparam logic signed [COEF_BITS-1:0] DEEP_Q15 [HIST_DEPTH] = '{
		16'sd725, 16'sd2958, 16'sd5483, 16'sd7471,
		16'sd7471, 16'sd5483, 16'sd2958, 16'sd725
	};
	localparam logic signed [COEF_BITS-1:0] SHALLOW_Q15 [HIST_DEPTH] = '{
		16'sd7401, 16'sd12802, 16'sd12802, 16'sd7401,
		16'sd0, 16'sd0, 16'sd0, 16'sd0
	};

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} tree_en_t;

	function automatic logic signed [COEF_BITS-1:0] tap_coef(
		input int   k,
		input logic deep,
		input int   long_taps,
		input int   short_taps
	);
		logic signed [COEF_BITS-1:0] c;
		c = '0;
		if (deep) begin
			if (k < long_taps) c = DEEP_Q15[k];
		end else begin
			if (k < short_taps) c = SHALLOW_Q15[k];
		end
		return c;
	endfunction

endpackage

### sv/fdf_tap_cell.sv
// ----------------------------------------------------------------------------
// fdf_tap_cell
// One tap of the filter: holds one history sample, hands it to the next
// cell on each accepted word, and forms the weighted product of its tap.
// ----------------------------------------------------------------------------
module fdf_tap_cell #(
	parameter int SAMPLE_BITS = fdf_pkg::SAMPLE_BITS_DEF,
	parameter int TAP         = 0,
	parameter int LONG_TAPS   = fdf_pkg::LONG_TAPS_DEF,
	parameter int SHORT_TAPS  = fdf_pkg::SHORT_TAPS_DEF,
	localparam int PROD_W     = SAMPLE_BITS + fdf_pkg::COEF_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic                     adv_s2,
	input  logic                     deep_s1,
	input  logic signed [SAMPLE_BITS-1:0] shift_in,
	output logic signed [SAMPLE_BITS-1:0] shift_out,
	output logic signed [PROD_W-1:0]      prod_s2
);

	logic signed [SAMPLE_BITS-1:0]         hist_q;
	logic signed [fdf_pkg::COEF_BITS-1:0]  coef;
	logic signed [PROD_W-1:0]              mult;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (load) begin
			hist_q <= shift_in;
		end
	end

	always_comb begin
		coef = fdf_pkg::tap_coef(TAP, deep_s1, LONG_TAPS, SHORT_TAPS);
		mult = PROD_W'(hist_q) * PROD_W'(coef);
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			prod_s2 <= mult;
		end
	end

	assign shift_out = hist_q;

endmodule

### sv/fdf_add_tree.sv
// ----------------------------------------------------------------------------
// fdf_add_tree
// Registered three-level adder tree that sums the eight tap products.
// ----------------------------------------------------------------------------
module fdf_add_tree #(
	parameter int PROD_W = fdf_pkg::SAMPLE_BITS_DEF + fdf_pkg::COEF_BITS,
	localparam int SUM_W = PROD_W + 3
) (
	input  logic                    clk,
	input  fdf_pkg::tree_en_t       en,
	input  logic signed [PROD_W-1:0] prod [fdf_pkg::HIST_DEPTH],
	output logic signed [SUM_W-1:0]  sum_s5
);

	logic signed [PROD_W:0]   pair_s3 [4];
	logic signed [PROD_W+1:0] quad_s4 [2];

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int i = 0; i < 4; i++) begin
				pair_s3[i] <= (PROD_W+1)'(prod[2*i]) + (PROD_W+1)'(prod[2*i+1]);
			end
		end
		if (en.s4) begin
			for (int i = 0; i < 2; i++) begin
				quad_s4[i] <= (PROD_W+2)'(pair_s3[2*i]) + (PROD_W+2)'(pair_s3[2*i+1]);
			end
		end
		if (en.s5) begin
			sum_s5 <= SUM_W'(quad_s4[0]) + SUM_W'(quad_s4[1]);
		end
	end

endmodule

### sv/dual_depth_fir_filter_unit.sv
// ----------------------------------------------------------------------------
// dual_depth_fir_filter_unit
// Eight-entry sample history feeding a fixed-coefficient low-pass FIR with
// a deep (eight-tap) and a shallow (four-tap) coefficient set per word.
//
//   channel    handshake                        payload
//   input      sample_valid / sample_stall      sample, deep_mode
//   output     filtered_valid / filtered_stall  filtered
//
// One word per cycle while the output does not stall; an accepted word passes
// the history registers, the products, three adder levels and the round/sat
// output register in that order before it shows on the output.
// Reset clears the sample history and all stage valid bits.
// Empty stages close up while the output stalls, so input keeps flowing
// until every stage is full.
// ----------------------------------------------------------------------------
module dual_depth_fir_filter_unit #(
	parameter int LONG_TAPS   = fdf_pkg::LONG_TAPS_DEF,
	parameter int SHORT_TAPS  = fdf_pkg::SHORT_TAPS_DEF,
	parameter int SAMPLE_BITS = fdf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          deep_mode,
	output logic                          filtered_valid,
	input  logic                          filtered_stall,
	output logic signed [SAMPLE_BITS-1:0] filtered
);

	localparam int PROD_W = SAMPLE_BITS + fdf_pkg::COEF_BITS;
	localparam int SUM_W  = PROD_W + 3;
	localparam int RND_W  = SUM_W + 1;
	localparam int Q_W    = RND_W - fdf_pkg::FRAC_BITS;
	localparam logic signed [RND_W-1:0] ROUND_HALF =
		RND_W'(1) << (fdf_pkg::FRAC_BITS - 1);
	localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [Q_W-1:0] SAT_LO = ~SAT_HI;

	logic signed [SAMPLE_BITS-1:0] hist [LONG_TAPS];
	logic signed [PROD_W-1:0]      prod [fdf_pkg::HIST_DEPTH];
	logic signed [SUM_W-1:0]       sum_s5;
	logic signed [RND_W-1:0]       rnd;
	logic signed [Q_W-1:0]         quo;
	logic signed [SAMPLE_BITS-1:0] sat;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic deep_s1;
	logic filtered_valid_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;

	logic out_free, rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic accept, adv_s2, adv_out;
	fdf_pkg::tree_en_t tree_en;

	// stage handshake
	always_comb begin
		out_free   = !filtered_valid_q || !filtered_stall;
		rdy_s5     = !valid_s5 || out_free;
		rdy_s4     = !valid_s4 || rdy_s5;
		rdy_s3     = !valid_s3 || rdy_s4;
		rdy_s2     = !valid_s2 || rdy_s3;
		rdy_s1     = !valid_s1 || rdy_s2;
		accept     = sample_valid && rdy_s1;
		adv_s2     = valid_s1 && rdy_s2;
		tree_en.s3 = valid_s2 && rdy_s3;
		tree_en.s4 = valid_s3 && rdy_s4;
		tree_en.s5 = valid_s4 && rdy_s5;
		adv_out    = valid_s5 && out_free;
	end

	assign sample_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			valid_s3         <= 1'b0;
			valid_s4         <= 1'b0;
			valid_s5         <= 1'b0;
			filtered_valid_q <= 1'b0;
		end else begin
			valid_s1         <= accept || (valid_s1 && !adv_s2);
			valid_s2         <= adv_s2 || (valid_s2 && !tree_en.s3);
			valid_s3         <= tree_en.s3 || (valid_s3 && !tree_en.s4);
			valid_s4         <= tree_en.s4 || (valid_s4 && !tree_en.s5);
			valid_s5         <= tree_en.s5 || (valid_s5 && !adv_out);
			filtered_valid_q <= adv_out || (filtered_valid_q && filtered_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			deep_s1 <= deep_mode;
		end
		if (adv_out) begin
			filtered_q <= sat;
		end
	end

	// tap cells, newest sample enters cell 0
	for (genvar k = 0; k < LONG_TAPS; k++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] shift_in;
		if (k == 0) begin : g_head
			assign shift_in = sample;
		end else begin : g_link
			assign shift_in = hist[k-1];
		end
		fdf_tap_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.TAP        (k),
			.LONG_TAPS  (LONG_TAPS),
			.SHORT_TAPS (SHORT_TAPS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (accept),
			.adv_s2   (adv_s2),
			.deep_s1  (deep_s1),
			.shift_in (shift_in),
			.shift_out(hist[k]),
			.prod_s2  (prod[k])
		);
	end

	for (genvar k = LONG_TAPS; k < fdf_pkg::HIST_DEPTH; k++) begin : g_pad
		assign prod[k] = '0;
	end

	fdf_add_tree #(
		.PROD_W(PROD_W)
	) u_tree (
		.clk   (clk),
		.en    (tree_en),
		.prod  (prod),
		.sum_s5(sum_s5)
	);

	// round half up, floor shift, saturate
	always_comb begin
		rnd = RND_W'(sum_s5) + ROUND_HALF;
		quo = Q_W'(rnd >>> fdf_pkg::FRAC_BITS);
		if (quo > SAT_HI) begin
			sat = SAMPLE_BITS'(SAT_HI);
		end else if (quo < SAT_LO) begin
			sat = SAMPLE_BITS'(SAT_LO);
		end else begin
			sat = SAMPLE_BITS'(quo);
		end
	end

	assign filtered_valid = filtered_valid_q;
	assign filtered       = filtered_q;

`ifndef SYNTHESIS
	a_head_load: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> hist[0] == $past(sample))
		else $error("head cell did not take the accepted word");

	a_chain_shift: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> hist[1] == $past(hist[0]))
		else $error("history chain did not shift");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5)
		else $error("input stalled with an empty stage");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && out_free |=> filtered_valid)
		else $error("finished word not presented on output");
`endif

endmodule
